@@ hdl/css_color_text_parser_defines.svh @@
// Assertion helpers for the colour parser.
`ifndef CSS_COLOR_TEXT_PARSER_DEFINES_SVH
`define CSS_COLOR_TEXT_PARSER_DEFINES_SVH

// Checked while out of reset.
`define CSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/csp_pkg.sv @@
package csp_pkg;

  localparam int NAME_COUNT = 18;
  localparam int NAME_W     = 8;
  localparam logic [3:0] COUNT_SAT = 4'd8;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_BODY  = 2'd1,
    PH_TRAIL = 2'd2
  } phase_e;

  // first character in element 0, padded with spaces to the full width
  typedef logic [0:NAME_W-1][7:0] name_text_t;

  localparam name_text_t NAME_TEXT [NAME_COUNT] = '{
    "black   ", "white   ", "silver  ", "gray    ", "grey    ", "maroon  ",
    "red     ", "purple  ", "fuchsia ", "green   ", "lime    ", "olive   ",
    "yellow  ", "navy    ", "blue    ", "teal    ", "aqua    ", "orange  "
  };

  localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
    4'd5, 4'd5, 4'd6, 4'd4, 4'd4, 4'd6, 4'd3, 4'd6, 4'd7,
    4'd5, 4'd4, 4'd5, 4'd6, 4'd4, 4'd4, 4'd4, 4'd4, 4'd6
  };

  // {red, green, blue}
  localparam logic [23:0] NAME_RGB [NAME_COUNT] = '{
    24'h000000, 24'hFFFFFF, 24'hC0C0C0, 24'h808080, 24'h808080, 24'h800000,
    24'hFF0000, 24'h800080, 24'hFF00FF, 24'h008000, 24'h00FF00, 24'h808000,
    24'hFFFF00, 24'h000080, 24'h0000FF, 24'h008080, 24'h00FFFF, 24'hFFA500
  };

  localparam logic [7:0] CH_HASH = 8'h23;

endpackage

@@ hdl/css_color_text_parser.sv @@
// CSS colour text parser. Bytes of a colour string arrive one item per cycle while no result
// waits on a stalled output, the final byte flagged by tlast; leading and trailing whitespace
// is skipped, and the string must be either '#' with 3 or 6 hex digits or one of the 18 basic
// colour names (case-insensitive). One result item leaves for every string, on its last byte:
// tuser is the valid flag, tdata the colour, zero when invalid. Throughput is one byte per
// cycle while the output is not stalled, the scan state being updated by a parallel compare
// against all 18 names; a result passes through an input register and a result register
// before it is offered. The parser is ready for a new string straight after a last byte.
`include "css_color_text_parser_defines.svh"

module css_color_text_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] character
  input  logic        s_axis_tlast_i,  // last_char
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [7:0] red, [15:8] green, [23:16] blue
  output logic        m_axis_tuser_o   // color_valid
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       adv;

  // scan state
  csp_pkg::phase_e                phase_q, phase_d;
  logic                           hash_q, hash_d;
  logic [3:0]                     count_q, count_d;
  logic [23:0]                    acc_q, acc_d;
  logic [csp_pkg::NAME_COUNT-1:0] cand_q, cand_d;
  logic                           err_q, err_d;

  // result register
  logic        out_valid_q;
  logic        out_ok_q;
  logic [23:0] out_rgb_q;

  logic        res_ok;
  logic [23:0] res_rgb;

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_comb begin
    logic       is_sp;
    logic       body;
    logic       is_hex;
    logic [3:0] digit;
    logic [7:0] lc;
    logic       found;

    phase_d = phase_q;
    hash_d  = hash_q;
    count_d = count_q;
    acc_d   = acc_q;
    cand_d  = cand_q;
    err_d   = err_q;
    body    = 1'b0;
    is_sp   = (in_char_q == 8'h20) || (in_char_q >= 8'h09 && in_char_q <= 8'h0D);

    case (phase_q)
      csp_pkg::PH_LEAD: begin
        if (!is_sp) begin
          phase_d = csp_pkg::PH_BODY;
          if (in_char_q == csp_pkg::CH_HASH) begin
            hash_d = 1'b1;
          end else begin
            body = 1'b1;
          end
        end
      end
      csp_pkg::PH_BODY: begin
        if (is_sp) begin
          phase_d = csp_pkg::PH_TRAIL;
        end else begin
          body = 1'b1;
        end
      end
      default: begin
        // non-space after trailing whitespace
        if (!is_sp) begin
          err_d = 1'b1;
        end
      end
    endcase

    // hex digit decode
    is_hex = 1'b1;
    digit  = 4'd0;
    if (in_char_q >= "0" && in_char_q <= "9") begin
      digit = 4'(in_char_q - "0");
    end else if (in_char_q >= "a" && in_char_q <= "f") begin
      digit = 4'(in_char_q - "a" + 8'd10);
    end else if (in_char_q >= "A" && in_char_q <= "F") begin
      digit = 4'(in_char_q - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end

    lc = (in_char_q >= "A" && in_char_q <= "Z") ? in_char_q + 8'd32 : in_char_q;

    if (body) begin
      if (hash_q) begin
        if (!is_hex) begin
          err_d = 1'b1;
        end
        acc_d = {acc_q[19:0], digit};
      end else begin
        for (int i = 0; i < csp_pkg::NAME_COUNT; i++) begin
          if (count_q >= csp_pkg::NAME_LEN[i] ||
              csp_pkg::NAME_TEXT[i][count_q[2:0]] != lc) begin
            cand_d[i] = 1'b0;
          end
        end
      end
      if (count_q < csp_pkg::COUNT_SAT) begin
        count_d = count_q + 4'd1;
      end
    end

    // verdict from the state after this byte
    res_ok  = 1'b0;
    res_rgb = 24'h000000;
    found   = 1'b0;
    if (phase_d != csp_pkg::PH_LEAD && !err_d) begin
      if (hash_d) begin
        if (count_d == 4'd3) begin
          res_ok  = 1'b1;
          res_rgb = {acc_d[3:0], acc_d[3:0], acc_d[7:4], acc_d[7:4],
                     acc_d[11:8], acc_d[11:8]};
        end else if (count_d == 4'd6) begin
          res_ok  = 1'b1;
          res_rgb = {acc_d[7:0], acc_d[15:8], acc_d[23:16]};
        end
      end else begin
        for (int i = 0; i < csp_pkg::NAME_COUNT; i++) begin
          if (!found && cand_d[i] && csp_pkg::NAME_LEN[i] == count_d) begin
            found   = 1'b1;
            res_ok  = 1'b1;
            res_rgb = {csp_pkg::NAME_RGB[i][7:0], csp_pkg::NAME_RGB[i][15:8],
                       csp_pkg::NAME_RGB[i][23:16]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= csp_pkg::PH_LEAD;
      hash_q  <= 1'b0;
      count_q <= 4'd0;
      acc_q   <= 24'h000000;
      cand_q  <= '1;
      err_q   <= 1'b0;
    end else if (adv) begin
      if (in_last_q) begin
        phase_q <= csp_pkg::PH_LEAD;
        hash_q  <= 1'b0;
        count_q <= 4'd0;
        acc_q   <= 24'h000000;
        cand_q  <= '1;
        err_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        hash_q  <= hash_d;
        count_q <= count_d;
        acc_q   <= acc_d;
        cand_q  <= cand_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      out_ok_q  <= res_ok;
      out_rgb_q <= res_rgb;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_ok_q;
  assign m_axis_tdata_o  = out_rgb_q;

  `CSP_ASSERT(a_invalid_is_black, clk_i, rst_ni,
    out_valid_q && !out_ok_q |-> out_rgb_q == 24'h000000, "invalid result with nonzero colour")
  `CSP_ASSERT(a_no_result_midstring, clk_i, rst_ni,
    adv && !in_last_q && !out_valid_q |=> !out_valid_q, "result raised by a non-final byte")
  `CSP_ASSERT(a_reset_after_last, clk_i, rst_ni,
    adv && in_last_q |=> phase_q == csp_pkg::PH_LEAD && !hash_q && count_q == 4'd0 &&
      cand_q == '1 && !err_q, "scan state not cleared after final byte")
  `CSP_ASSERT(a_hash_in_body, clk_i, rst_ni,
    hash_q |-> phase_q != csp_pkg::PH_LEAD, "hash flag set while still in leading space")
  `CSP_ASSERT_ALWAYS(a_stall_cause, clk_i,
    !s_axis_tready_o |-> in_valid_q && out_valid_q && !m_axis_tready_i,
    "input stalled without a blocked result")

endmodule

@@ verif/tb_css_color_text_parser.sv @@
module tb_css_color_text_parser;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] char_t;
  typedef struct packed {
    char_t ch;
    logic  last;
  } text_item_t;
  typedef struct packed {
    logic  ok;
    char_t red;
    char_t green;
    char_t blue;
  } color_t;

  localparam int NUM_NAMES    = 18;
  localparam int RANDOM_BYTES = 650;
  localparam int HOLD_CYCLES  = 300;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  char_t       s_axis_tdata   = '0;  // [7:0] character
  logic        s_axis_tlast   = 1'b0;  // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [23:0] m_axis_tdata;  // [7:0] red, [15:8] green, [23:16] blue
  logic        m_axis_tuser;  // color_valid

  css_color_text_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  string color_names [NUM_NAMES] = '{
    "black", "white", "silver", "gray", "grey", "maroon", "red", "purple", "fuchsia",
    "green", "lime", "olive", "yellow", "navy", "blue", "teal", "aqua", "orange"
  };
  // {red, green, blue}
  logic [23:0] color_rgb [NUM_NAMES] = '{
    24'h000000, 24'hFFFFFF, 24'hC0C0C0, 24'h808080, 24'h808080, 24'h800000,
    24'hFF0000, 24'h800080, 24'hFF00FF, 24'h008000, 24'h00FF00, 24'h808000,
    24'hFFFF00, 24'h000080, 24'h0000FF, 24'h008080, 24'h00FFFF, 24'hFFA500
  };

  text_item_t  pending_text [$];
  color_t      due_colors [$];
  int          fail_cnt  = 0;
  int          sent_cnt  = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  // scan state of the string in flight
  csp_pkg::phase_e scan_ph = csp_pkg::PH_LEAD;
  logic        seen_hash = 1'b0;
  logic [3:0]  body_len  = '0;
  logic [23:0] hex_acc   = '0;
  logic [17:0] name_live = '1;
  logic        bad_text  = 1'b0;

  assign calm = (sent_cnt >= 250) && (sent_cnt < 400);

  function automatic void track_char(char_t c, logic last);
    logic       blank;
    logic [3:0] dig;
    char_t      lc;
    color_t     res;
    blank = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    if (blank) begin
      if (scan_ph == csp_pkg::PH_BODY) scan_ph = csp_pkg::PH_TRAIL;
    end else if (scan_ph == csp_pkg::PH_LEAD && c == csp_pkg::CH_HASH) begin
      scan_ph   = csp_pkg::PH_BODY;
      seen_hash = 1'b1;
    end else if (scan_ph == csp_pkg::PH_LEAD || scan_ph == csp_pkg::PH_BODY) begin
      scan_ph = csp_pkg::PH_BODY;
      if (seen_hash) begin
        dig = '0;
        if (c >= "0" && c <= "9") begin
          dig = c[3:0];
        end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
          dig = c[3:0] + 4'd9;  // 'a' and 'A' have low nibble 1
        end else begin
          bad_text = 1'b1;
        end
        hex_acc = {hex_acc[19:0], dig};
      end else begin
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        for (int i = 0; i < NUM_NAMES; i++) begin
          if (name_live[i] && (body_len >= color_names[i].len() ||
                               color_names[i][body_len] != lc))
            name_live[i] = 1'b0;
        end
      end
      if (body_len < 4'd8) body_len++;
    end else begin
      bad_text = 1'b1;  // text after trailing blanks
    end

    if (!last) return;

    res = '0;
    if (scan_ph != csp_pkg::PH_LEAD && !bad_text) begin
      if (seen_hash) begin
        if (body_len == 4'd3) begin
          res.ok    = 1'b1;
          res.red   = hex_acc[11:8] * 8'd17;
          res.green = hex_acc[7:4] * 8'd17;
          res.blue  = hex_acc[3:0] * 8'd17;
        end else if (body_len == 4'd6) begin
          res = {1'b1, hex_acc};
        end
      end else begin
        for (int i = 0; i < NUM_NAMES; i++) begin
          if (!res.ok && name_live[i] && color_names[i].len() == body_len)
            res = {1'b1, color_rgb[i]};
        end
      end
    end
    due_colors.push_back(res);
    scan_ph   = csp_pkg::PH_LEAD;
    seen_hash = 1'b0;
    body_len  = '0;
    hex_acc   = '0;
    name_live = '1;
    bad_text  = 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_cnt++;
  endtask

  function automatic char_t rand_space();
    char_t blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    return blanks[$urandom_range(0, 5)];
  endfunction

  function automatic char_t rand_hex();
    string digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic char_t rand_case(char_t c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
    return c;
  endfunction

  function automatic void add_bytes(char_t s [$]);
    foreach (s[k]) pending_text.push_back('{ch: s[k], last: (k == s.size() - 1)});
  endfunction

  function automatic void add_text(string t);
    char_t s [$];
    for (int k = 0; k < t.len(); k++) s.push_back(t[k]);
    add_bytes(s);
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // sender
  always @(posedge clk_i) begin
    text_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_char(s_axis_tdata, s_axis_tlast);
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_text.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
          it = pending_text.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= it.ch;
          s_axis_tlast  <= it.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while the sender keeps offering
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_cnt >= 100) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 38);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    color_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_colors.size() == 0) begin
        report_mismatch("result item with no colour pending");
      end else begin
        want = due_colors.pop_front();
        if (m_axis_tuser !== want.ok)
          report_mismatch($sformatf("valid %b, want %b", m_axis_tuser, want.ok));
        if (m_axis_tdata[7:0] !== want.red)
          report_mismatch($sformatf("red %h, want %h", m_axis_tdata[7:0], want.red));
        if (m_axis_tdata[15:8] !== want.green)
          report_mismatch($sformatf("green %h, want %h", m_axis_tdata[15:8], want.green));
        if (m_axis_tdata[23:16] !== want.blue)
          report_mismatch($sformatf("blue %h, want %h", m_axis_tdata[23:16], want.blue));
      end
    end
  end

  initial begin
    char_t s [$];
    string nm;
    int    kind;
    int    n;
    int    start;
    int    random_bytes;

    // directed strings
    add_text("#FfA");
    add_text("\tBLUE ");
    add_text("#");
    add_text(" ");
    s = {8'hFF, 8'h01};
    add_bytes(s);
    add_text("#00e9Cb");
    add_text("gr y");
    add_text("#1g2");

    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      s = {};
      repeat ($urandom_range(0, 2)) s.push_back(rand_space());
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        nm    = color_names[$urandom_range(0, NUM_NAMES - 1)];
        start = s.size();
        for (int k = 0; k < nm.len(); k++) s.push_back(rand_case(nm[k]));
        if (kind >= 4) begin
          case ($urandom_range(0, 4))
            0: s.delete(s.size() - 1);
            1: s.push_back(rand_case(char_t'($urandom_range(8'h61, 8'h7A))));
            2: s[start + $urandom_range(0, nm.len() - 1)] = char_t'($urandom_range(1, 255));
            3: s.insert(start + $urandom_range(1, nm.len() - 1), rand_space());
            default: for (int k = 0; k < nm.len(); k++) s.push_back(rand_case(nm[k]));
          endcase
        end
      end else if (kind <= 7) begin
        s.push_back(csp_pkg::CH_HASH);
        repeat ($urandom_range(0, 1) ? 6 : 3) s.push_back(rand_hex());
      end else if (kind == 8) begin
        s.push_back(csp_pkg::CH_HASH);
        start = s.size();
        n     = $urandom_range(0, 9);
        repeat (n) s.push_back(rand_hex());
        if (n != 0 && $urandom_range(0, 2) == 0)
          s[start + $urandom_range(0, n - 1)] = char_t'($urandom_range(1, 255));
      end else begin
        repeat ($urandom_range(1, 10)) s.push_back(char_t'($urandom_range(1, 255)));
      end
      repeat ($urandom_range(0, 2)) s.push_back(rand_space());
      add_bytes(s);
      random_bytes += s.size();
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_text.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (due_colors.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_cnt == 0 && due_colors.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
